@@ sv/hrlp_pkg.sv @@
// Shared types and constants for the HTTP request line parser.
// No dependencies; imported by hrlp_classify and http_request_line_parser_core.
`timescale 1ns / 1ps
`default_nettype none

package hrlp_pkg;

    localparam int OFF_W     = 12;
    localparam int STATUS_W  = 3;
    localparam int VERSION_W = 11;
    localparam int MINOR_W   = 10;

    localparam logic [STATUS_W-1:0] ST_MORE        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DONE        = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_METHOD  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_REQUEST = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_VERSION = 3'd4;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG    = 3'd5;

    localparam logic [VERSION_W-1:0] VERSION_BASE  = 11'd1000;
    localparam logic [MINOR_W-1:0]   MINOR_LIMIT   = 10'd99;

    // one bit per byte value: set for plain URI bytes
    localparam logic [255:0] USUAL_MAP = {
        32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
        32'hffffffff, 32'hffffffff, 32'h7fff37d6, 32'hffffdbfe
    };

    typedef struct packed {
        logic       usual;
        logic       method;
        logic       digit;
        logic       nz_digit;
        logic [3:0] digit_val;
        logic       is_cr;
        logic       is_lf;
        logic       is_sp;
        logic       is_slash;
        logic       is_dot;
        logic       is_one;
        logic       is_g;
        logic       is_e;
        logic       is_h;
        logic       is_t;
        logic       is_p;
    } t_byte_class;

endpackage

`default_nettype wire

@@ sv/hrlp_classify.sv @@
// Byte classifier: decodes one request byte into character classes.
// Depends on hrlp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hrlp_classify (
    input  wire logic [7:0]           i_byte,
    output hrlp_pkg::t_byte_class     o_class
);
    import hrlp_pkg::*;

    always_comb begin
        o_class           = '0;
        o_class.usual     = USUAL_MAP[i_byte];
        o_class.method    = (i_byte >= 8'h41 && i_byte <= 8'h5a) || i_byte == 8'h5f
                            || i_byte == 8'h2d;
        o_class.digit     = i_byte >= 8'h30 && i_byte <= 8'h39;
        o_class.nz_digit  = i_byte >= 8'h31 && i_byte <= 8'h39;
        o_class.digit_val = i_byte[3:0];
        o_class.is_cr     = i_byte == 8'h0d;
        o_class.is_lf     = i_byte == 8'h0a;
        o_class.is_sp     = i_byte == 8'h20;
        o_class.is_slash  = i_byte == 8'h2f;
        o_class.is_dot    = i_byte == 8'h2e;
        o_class.is_one    = i_byte == 8'h31;
        o_class.is_g      = i_byte == 8'h47;
        o_class.is_e      = i_byte == 8'h45;
        o_class.is_h      = i_byte == 8'h48;
        o_class.is_t      = i_byte == 8'h54;
        o_class.is_p      = i_byte == 8'h50;
    end

endmodule

`default_nettype wire

@@ sv/http_request_line_parser_core.sv @@
// Top level of the HTTP request line parser: input register, parse state, result register.
// Depends on hrlp_pkg and hrlp_classify.
//
//   channel | handshake               | payload
//   --------+-------------------------+------------------------------------------
//   in      | i_valid, o_stall        | i_data_byte
//   out     | o_valid, i_stall        | o_status, o_http_version, o_uri_begin,
//           |                         | o_uri_finish, o_ext_begin, o_ext_present,
//           |                         | o_proto_begin, o_line_finish, o_uri_had_space
//
// One byte per cycle while i_stall is low; an accepted byte waits in the input register, then its status is registered.
// The parse step is combinational between the input register and the result register.
// Synchronous active-low reset empties both registers and returns the parser to start.
// A stall on the out side holds the result register and backs up into o_stall.
`timescale 1ns / 1ps
`default_nettype none

module http_request_line_parser_core #(
    parameter int LINE_BUFFER_BYTES = 4096
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output      logic                           o_stall,
    input  wire logic [7:0]                     i_data_byte,
    output      logic                           o_valid,
    input  wire logic                           i_stall,
    output      logic [hrlp_pkg::STATUS_W-1:0]  o_status,
    output      logic [hrlp_pkg::VERSION_W-1:0] o_http_version,
    output      logic [hrlp_pkg::OFF_W-1:0]     o_uri_begin,
    output      logic [hrlp_pkg::OFF_W-1:0]     o_uri_finish,
    output      logic [hrlp_pkg::OFF_W-1:0]     o_ext_begin,
    output      logic                           o_ext_present,
    output      logic [hrlp_pkg::OFF_W-1:0]     o_proto_begin,
    output      logic [hrlp_pkg::OFF_W-1:0]     o_line_finish,
    output      logic                           o_uri_had_space
);
    import hrlp_pkg::*;

    localparam int CNT_W = $clog2(LINE_BUFFER_BYTES + 1);

    typedef enum logic [3:0] {
        PH_START, PH_METHOD, PH_PRE_URI, PH_SLASH, PH_URI, PH_POST_URI,
        PH_T1, PH_T2, PH_P, PH_VSLASH, PH_MAJOR, PH_DOT, PH_MINOR1, PH_MINOR,
        PH_TRAIL, PH_LF
    } t_phase;

    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    logic               r_out_valid;

    t_phase             r_phase, n_phase;
    logic [CNT_W-1:0]   r_offset, n_offset;
    logic [2:0]         r_mlen, n_mlen;
    logic               r_is_get, n_is_get;
    logic [OFF_W-1:0]   r_uri_begin, n_uri_begin;
    logic [OFF_W-1:0]   r_uri_finish, n_uri_finish;
    logic [OFF_W-1:0]   r_ext_begin, n_ext_begin;
    logic               r_ext_valid, n_ext_valid;
    logic [OFF_W-1:0]   r_proto_begin, n_proto_begin;
    logic [OFF_W-1:0]   r_cr_off, n_cr_off;
    logic [MINOR_W-1:0] r_minor, n_minor;
    logic               r_space_seen, n_space_seen;

    logic [STATUS_W-1:0]  r_status, n_status;
    logic [VERSION_W-1:0] r_version, n_version;
    logic [OFF_W-1:0]     r_o_uri_begin, n_o_uri_begin;
    logic [OFF_W-1:0]     r_o_uri_finish, n_o_uri_finish;
    logic [OFF_W-1:0]     r_o_ext_begin, n_o_ext_begin;
    logic                 r_o_ext_present, n_o_ext_present;
    logic [OFF_W-1:0]     r_o_proto_begin, n_o_proto_begin;
    logic [OFF_W-1:0]     r_o_line_finish, n_o_line_finish;
    logic                 r_o_space, n_o_space;

    t_byte_class        cls;
    logic               out_adv;
    logic               step;
    logic [OFF_W-1:0]   off;
    logic               u_bad, u_dot, u_slash, u_space;
    t_phase             u_phase;
    logic [STATUS_W-1:0] st;
    logic               done;

    hrlp_classify u_classify (
        .i_byte  (r_in_byte),
        .o_class (cls)
    );

    assign out_adv = !r_out_valid || !i_stall;
    assign step    = r_in_valid && out_adv;
    assign o_stall = r_in_valid && !out_adv;
    assign off     = OFF_W'(r_offset);

    always_comb begin
        u_bad   = 1'b0;
        u_dot   = 1'b0;
        u_slash = 1'b0;
        u_space = 1'b0;
        u_phase = PH_URI;
        if (cls.usual) begin
            u_phase = PH_URI;
        end else if (cls.is_slash) begin
            u_slash = 1'b1;
            u_phase = PH_SLASH;
        end else if (cls.is_dot) begin
            u_dot = 1'b1;
        end else if (cls.is_sp) begin
            u_space = 1'b1;
            u_phase = PH_POST_URI;
        end else begin
            u_bad = 1'b1;
        end
    end

    always_comb begin
        n_phase       = r_phase;
        n_offset      = r_offset;
        n_mlen        = r_mlen;
        n_is_get      = r_is_get;
        n_uri_begin   = r_uri_begin;
        n_uri_finish  = r_uri_finish;
        n_ext_begin   = r_ext_begin;
        n_ext_valid   = r_ext_valid;
        n_proto_begin = r_proto_begin;
        n_cr_off      = r_cr_off;
        n_minor       = r_minor;
        n_space_seen  = r_space_seen;
        st            = ST_MORE;
        done          = 1'b0;

        if (r_phase != PH_START && r_offset >= CNT_W'(LINE_BUFFER_BYTES)) begin
            st = ST_TOO_LONG;
        end else begin
            case (r_phase)
                PH_START: begin
                    if (!(cls.is_cr || cls.is_lf)) begin
                        if (!cls.method) begin
                            st = ST_BAD_METHOD;
                        end else begin
                            n_mlen   = 3'd1;
                            n_is_get = cls.is_g;
                            n_phase  = PH_METHOD;
                        end
                    end
                end
                PH_METHOD: begin
                    if (cls.is_sp) begin
                        if (r_mlen == 3'd3 && r_is_get) begin
                            n_phase = PH_PRE_URI;
                        end else begin
                            st = ST_BAD_METHOD;
                        end
                    end else if (!cls.method) begin
                        st = ST_BAD_METHOD;
                    end else begin
                        if ((r_mlen == 3'd1 && !cls.is_e) || (r_mlen == 3'd2 && !cls.is_t)
                            || r_mlen >= 3'd3) begin
                            n_is_get = 1'b0;
                        end
                        if (r_mlen < 3'd4) begin
                            n_mlen = r_mlen + 3'd1;
                        end
                    end
                end
                PH_PRE_URI: begin
                    if (cls.is_slash) begin
                        n_uri_begin = off;
                        n_phase     = PH_SLASH;
                    end else if (!cls.is_sp) begin
                        st = ST_BAD_REQUEST;
                    end
                end
                PH_SLASH: begin
                    if (cls.usual) begin
                        n_phase = PH_URI;
                    end else if (cls.is_sp) begin
                        n_uri_finish = off;
                        n_phase      = PH_POST_URI;
                    end else begin
                        st = ST_BAD_VERSION;
                    end
                end
                PH_URI, PH_POST_URI: begin
                    if (r_phase == PH_POST_URI && cls.is_sp) begin
                        n_phase = PH_POST_URI;
                    end else if (r_phase == PH_POST_URI && (cls.is_cr || cls.is_lf)) begin
                        st = ST_BAD_VERSION;
                    end else if (r_phase == PH_POST_URI && cls.is_h) begin
                        n_proto_begin = off;
                        n_phase       = PH_T1;
                    end else begin
                        if (r_phase == PH_POST_URI) begin
                            n_space_seen = 1'b1;
                        end
                        n_phase = u_phase;
                        if (u_slash) begin
                            n_ext_valid = 1'b0;
                        end
                        if (u_dot) begin
                            n_ext_begin = off + OFF_W'(1);
                            n_ext_valid = 1'b1;
                        end
                        if (u_space) begin
                            n_uri_finish = off;
                        end
                        if (u_bad) begin
                            st = ST_BAD_REQUEST;
                        end
                    end
                end
                PH_T1: begin
                    if (cls.is_t) n_phase = PH_T2;
                    else          st = ST_BAD_REQUEST;
                end
                PH_T2: begin
                    if (cls.is_t) n_phase = PH_P;
                    else          st = ST_BAD_REQUEST;
                end
                PH_P: begin
                    if (cls.is_p) n_phase = PH_VSLASH;
                    else          st = ST_BAD_REQUEST;
                end
                PH_VSLASH: begin
                    if (cls.is_slash) n_phase = PH_MAJOR;
                    else              st = ST_BAD_REQUEST;
                end
                PH_MAJOR: begin
                    if (!cls.nz_digit)    st = ST_BAD_REQUEST;
                    else if (!cls.is_one) st = ST_BAD_VERSION;
                    else                  n_phase = PH_DOT;
                end
                PH_DOT: begin
                    if (cls.is_dot)      n_phase = PH_MINOR1;
                    else if (!cls.digit) st = ST_BAD_REQUEST;
                    else                 st = ST_BAD_VERSION;
                end
                PH_MINOR1: begin
                    if (cls.digit) begin
                        n_minor = MINOR_W'(cls.digit_val);
                        n_phase = PH_MINOR;
                    end else begin
                        st = ST_BAD_REQUEST;
                    end
                end
                PH_MINOR: begin
                    if (cls.is_cr) begin
                        n_cr_off = off;
                        n_phase  = PH_LF;
                    end else if (cls.is_lf) begin
                        done = 1'b1;
                    end else if (cls.is_sp) begin
                        n_phase = PH_TRAIL;
                    end else if (!cls.digit || r_minor > MINOR_LIMIT) begin
                        st = ST_BAD_REQUEST;
                    end else begin
                        n_minor = (r_minor << 3) + (r_minor << 1) + MINOR_W'(cls.digit_val);
                    end
                end
                PH_TRAIL: begin
                    if (cls.is_cr) begin
                        n_cr_off = off;
                        n_phase  = PH_LF;
                    end else if (cls.is_lf) begin
                        done = 1'b1;
                    end else if (!cls.is_sp) begin
                        st = ST_BAD_REQUEST;
                    end
                end
                PH_LF: begin
                    if (cls.is_lf) done = 1'b1;
                    else           st = ST_BAD_REQUEST;
                end
                default: begin
                    st = ST_BAD_REQUEST;
                end
            endcase
        end

        n_status        = st;
        n_version       = '0;
        n_o_uri_begin   = '0;
        n_o_uri_finish  = '0;
        n_o_ext_begin   = '0;
        n_o_ext_present = 1'b0;
        n_o_proto_begin = '0;
        n_o_line_finish = '0;
        n_o_space       = 1'b0;

        if (st == ST_MORE && done) begin
            n_status        = ST_DONE;
            n_version       = VERSION_BASE + VERSION_W'(r_minor);
            n_o_uri_begin   = r_uri_begin;
            n_o_uri_finish  = r_uri_finish;
            n_o_ext_begin   = r_ext_valid ? r_ext_begin : '0;
            n_o_ext_present = r_ext_valid;
            n_o_proto_begin = r_proto_begin;
            n_o_line_finish = (r_phase == PH_LF) ? r_cr_off : off;
            n_o_space       = r_space_seen;
        end

        if (st != ST_MORE || done) begin
            n_phase       = PH_START;
            n_offset      = '0;
            n_mlen        = '0;
            n_is_get      = 1'b1;
            n_uri_begin   = '0;
            n_uri_finish  = '0;
            n_ext_begin   = '0;
            n_ext_valid   = 1'b0;
            n_proto_begin = '0;
            n_cr_off      = '0;
            n_minor       = '0;
            n_space_seen  = 1'b0;
        end else if (n_phase != PH_START) begin
            n_offset = r_offset + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_phase       <= PH_START;
            r_offset      <= '0;
            r_mlen        <= '0;
            r_is_get      <= 1'b1;
            r_uri_begin   <= '0;
            r_uri_finish  <= '0;
            r_ext_begin   <= '0;
            r_ext_valid   <= 1'b0;
            r_proto_begin <= '0;
            r_cr_off      <= '0;
            r_minor       <= '0;
            r_space_seen  <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (out_adv) begin
                r_out_valid <= r_in_valid;
            end
            if (step) begin
                r_phase       <= n_phase;
                r_offset      <= n_offset;
                r_mlen        <= n_mlen;
                r_is_get      <= n_is_get;
                r_uri_begin   <= n_uri_begin;
                r_uri_finish  <= n_uri_finish;
                r_ext_begin   <= n_ext_begin;
                r_ext_valid   <= n_ext_valid;
                r_proto_begin <= n_proto_begin;
                r_cr_off      <= n_cr_off;
                r_minor       <= n_minor;
                r_space_seen  <= n_space_seen;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_byte <= i_data_byte;
        end
        if (step) begin
            r_status        <= n_status;
            r_version       <= n_version;
            r_o_uri_begin   <= n_o_uri_begin;
            r_o_uri_finish  <= n_o_uri_finish;
            r_o_ext_begin   <= n_o_ext_begin;
            r_o_ext_present <= n_o_ext_present;
            r_o_proto_begin <= n_o_proto_begin;
            r_o_line_finish <= n_o_line_finish;
            r_o_space       <= n_o_space;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_status;
    assign o_http_version  = r_version;
    assign o_uri_begin     = r_o_uri_begin;
    assign o_uri_finish    = r_o_uri_finish;
    assign o_ext_begin     = r_o_ext_begin;
    assign o_ext_present   = r_o_ext_present;
    assign o_proto_begin   = r_o_proto_begin;
    assign o_line_finish   = r_o_line_finish;
    assign o_uri_had_space = r_o_space;

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// Testbench for http_request_line_parser_core: a clocked driver sends request line bytes,
// a clocked monitor checks every status item against a byte-level parser model.
// Depends on hrlp_pkg for status codes, field widths and the URI byte map.
`timescale 1ns / 1ps

module tb_top;
    import hrlp_pkg::*;

    localparam logic [7:0]  CH_CR      = 8'h0d;
    localparam logic [7:0]  CH_LF      = 8'h0a;
    localparam logic [12:0] LINE_BYTES = 13'd4096;

    typedef enum logic [3:0] {
        PH_START, PH_METHOD, PH_PRE_URI, PH_SLASH, PH_URI, PH_URI_SP,
        PH_PROTO_H, PH_PROTO_T1, PH_PROTO_T2, PH_PROTO_P,
        PH_MAJOR_FIRST, PH_MAJOR, PH_MINOR_FIRST, PH_MINOR, PH_TRAIL, PH_CR
    } t_parse_phase;

    typedef enum int {END_NONE, END_LF, END_CRLF} t_line_end;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [VERSION_W-1:0] version;
        logic [OFF_W-1:0]     uri_begin;
        logic [OFF_W-1:0]     uri_finish;
        logic [OFF_W-1:0]     ext_begin;
        logic                 ext_present;
        logic [OFF_W-1:0]     proto_begin;
        logic [OFF_W-1:0]     line_finish;
        logic                 had_space;
    } t_parse_result;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_valid     = 1'b0;
    logic [7:0]           i_data_byte = 8'h00;
    logic                 i_stall     = 1'b0;
    logic                 o_stall;
    logic                 o_valid;
    logic [STATUS_W-1:0]  o_status;
    logic [VERSION_W-1:0] o_http_version;
    logic [OFF_W-1:0]     o_uri_begin;
    logic [OFF_W-1:0]     o_uri_finish;
    logic [OFF_W-1:0]     o_ext_begin;
    logic                 o_ext_present;
    logic [OFF_W-1:0]     o_proto_begin;
    logic [OFF_W-1:0]     o_line_finish;
    logic                 o_uri_had_space;

    http_request_line_parser_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_data_byte     (i_data_byte),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_http_version  (o_http_version),
        .o_uri_begin     (o_uri_begin),
        .o_uri_finish    (o_uri_finish),
        .o_ext_begin     (o_ext_begin),
        .o_ext_present   (o_ext_present),
        .o_proto_begin   (o_proto_begin),
        .o_line_finish   (o_line_finish),
        .o_uri_had_space (o_uri_had_space)
    );

    logic [7:0]    pending_bytes[$];
    logic [7:0]    line_buf[$];
    t_parse_result line_status_q[$];
    t_parse_result want;
    t_parse_result got;

    int  bytes_queued = 0;
    int  bytes_taken  = 0;
    int  results_seen = 0;
    int  mismatches   = 0;
    int  status_count[0:7];
    int  send_gap     = 0;
    int  stall_left   = 0;
    bit  byte_taken   = 1'b0;
    bit  calm         = 1'b0;

    t_parse_phase     ps_phase;
    logic [12:0]      ps_offset;
    logic [2:0]       ps_mlen;
    logic             ps_get;
    logic [OFF_W-1:0] ps_uri_b;
    logic [OFF_W-1:0] ps_uri_f;
    logic [OFF_W-1:0] ps_ext_b;
    logic             ps_ext_ok;
    logic [OFF_W-1:0] ps_proto_b;
    logic             ps_cr_ok;
    logic [OFF_W-1:0] ps_cr_off;
    int               ps_major;
    int               ps_minor;
    logic             ps_space;

    function automatic void parser_restart();
        ps_phase   = PH_START;
        ps_offset  = '0;
        ps_mlen    = '0;
        ps_get     = 1'b1;
        ps_uri_b   = '0;
        ps_uri_f   = '0;
        ps_ext_b   = '0;
        ps_ext_ok  = 1'b0;
        ps_proto_b = '0;
        ps_cr_ok   = 1'b0;
        ps_cr_off  = '0;
        ps_major   = 0;
        ps_minor   = 0;
        ps_space   = 1'b0;
    endfunction

    function automatic bit is_method_byte(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || c == "_" || c == "-";
    endfunction

    function automatic bit is_digit_byte(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic [STATUS_W-1:0] take_uri_byte(input logic [7:0] c,
                                                          input logic [12:0] o);
        take_uri_byte = ST_MORE;
        if (USUAL_MAP[c]) begin
            ps_phase = PH_URI;
        end else if (c == "/") begin
            ps_ext_ok = 1'b0;
            ps_phase  = PH_SLASH;
        end else if (c == ".") begin
            ps_ext_b  = o[OFF_W-1:0] + 12'd1;
            ps_ext_ok = 1'b1;
            ps_phase  = PH_URI;
        end else if (c == " ") begin
            ps_uri_f = o[OFF_W-1:0];
            ps_phase = PH_URI_SP;
        end else begin
            take_uri_byte = ST_BAD_REQUEST;
        end
    endfunction

    function automatic t_parse_result parse_byte(input logic [7:0] c);
        t_parse_result       r;
        logic [STATUS_W-1:0] st;
        logic                done;
        logic [12:0]         o;
        r    = '0;
        st   = ST_MORE;
        done = 1'b0;
        o    = ps_offset;
        if (ps_phase != PH_START && ps_offset >= LINE_BYTES) begin
            parser_restart();
            r.status = ST_TOO_LONG;
            return r;
        end
        case (ps_phase)
            PH_START: begin
                if (c != CH_CR && c != CH_LF) begin
                    if (!is_method_byte(c)) begin
                        st = ST_BAD_METHOD;
                    end else begin
                        ps_mlen  = 3'd1;
                        ps_get   = (c == "G");
                        ps_phase = PH_METHOD;
                    end
                end
            end
            PH_METHOD: begin
                if (c == " ") begin
                    if (ps_mlen == 3'd3 && ps_get) ps_phase = PH_PRE_URI;
                    else st = ST_BAD_METHOD;
                end else if (!is_method_byte(c)) begin
                    st = ST_BAD_METHOD;
                end else begin
                    if (ps_mlen == 3'd1 && c != "E") ps_get = 1'b0;
                    else if (ps_mlen == 3'd2 && c != "T") ps_get = 1'b0;
                    else if (ps_mlen >= 3'd3) ps_get = 1'b0;
                    if (ps_mlen < 3'd4) ps_mlen = ps_mlen + 3'd1;
                end
            end
            PH_PRE_URI: begin
                if (c == "/") begin
                    ps_uri_b = o[OFF_W-1:0];
                    ps_phase = PH_SLASH;
                end else if (c != " ") begin
                    st = ST_BAD_REQUEST;
                end
            end
            PH_SLASH: begin
                if (USUAL_MAP[c]) begin
                    ps_phase = PH_URI;
                end else if (c == " ") begin
                    ps_uri_f = o[OFF_W-1:0];
                    ps_phase = PH_URI_SP;
                end else begin
                    st = ST_BAD_VERSION;
                end
            end
            PH_URI: st = take_uri_byte(c, o);
            PH_URI_SP: begin
                if (c == CH_CR || c == CH_LF) begin
                    st = ST_BAD_VERSION;
                end else if (c == "H") begin
                    ps_proto_b = o[OFF_W-1:0];
                    ps_phase   = PH_PROTO_H;
                end else if (c != " ") begin
                    ps_space = 1'b1;
                    st       = take_uri_byte(c, o);
                end
            end
            PH_PROTO_H: begin
                if (c == "T") ps_phase = PH_PROTO_T1;
                else st = ST_BAD_REQUEST;
            end
            PH_PROTO_T1: begin
                if (c == "T") ps_phase = PH_PROTO_T2;
                else st = ST_BAD_REQUEST;
            end
            PH_PROTO_T2: begin
                if (c == "P") ps_phase = PH_PROTO_P;
                else st = ST_BAD_REQUEST;
            end
            PH_PROTO_P: begin
                if (c == "/") ps_phase = PH_MAJOR_FIRST;
                else st = ST_BAD_REQUEST;
            end
            PH_MAJOR_FIRST: begin
                if (c < "1" || c > "9") begin
                    st = ST_BAD_REQUEST;
                end else if (c > "1") begin
                    st = ST_BAD_VERSION;
                end else begin
                    ps_major = 1;
                    ps_phase = PH_MAJOR;
                end
            end
            PH_MAJOR: begin
                if (c == ".") begin
                    ps_phase = PH_MINOR_FIRST;
                end else if (!is_digit_byte(c)) begin
                    st = ST_BAD_REQUEST;
                end else if (ps_major * 10 + (int'(c) - 48) > 1) begin
                    st = ST_BAD_VERSION;
                end else begin
                    ps_major = ps_major * 10 + (int'(c) - 48);
                end
            end
            PH_MINOR_FIRST: begin
                if (is_digit_byte(c)) begin
                    ps_minor = int'(c) - 48;
                    ps_phase = PH_MINOR;
                end else begin
                    st = ST_BAD_REQUEST;
                end
            end
            PH_MINOR: begin
                if (c == CH_CR) begin
                    ps_cr_ok  = 1'b1;
                    ps_cr_off = o[OFF_W-1:0];
                    ps_phase  = PH_CR;
                end else if (c == CH_LF) begin
                    done = 1'b1;
                end else if (c == " ") begin
                    ps_phase = PH_TRAIL;
                end else if (!is_digit_byte(c) || ps_minor > 99) begin
                    st = ST_BAD_REQUEST;
                end else begin
                    ps_minor = ps_minor * 10 + (int'(c) - 48);
                end
            end
            PH_TRAIL: begin
                if (c == CH_CR) begin
                    ps_cr_ok  = 1'b1;
                    ps_cr_off = o[OFF_W-1:0];
                    ps_phase  = PH_CR;
                end else if (c == CH_LF) begin
                    done = 1'b1;
                end else if (c != " ") begin
                    st = ST_BAD_REQUEST;
                end
            end
            default: begin
                if (c == CH_LF) done = 1'b1;
                else st = ST_BAD_REQUEST;
            end
        endcase

        if (st != ST_MORE) begin
            parser_restart();
            r.status = st;
        end else if (done) begin
            r.status      = ST_DONE;
            r.version     = 11'(ps_major * 1000 + ps_minor);
            r.uri_begin   = ps_uri_b;
            r.uri_finish  = ps_uri_f;
            r.ext_begin   = ps_ext_ok ? ps_ext_b : '0;
            r.ext_present = ps_ext_ok;
            r.proto_begin = ps_proto_b;
            r.line_finish = ps_cr_ok ? ps_cr_off : o[OFF_W-1:0];
            r.had_space   = ps_space;
            parser_restart();
        end else if (ps_phase != PH_START) begin
            ps_offset = o + 13'd1;
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [11:0] exp_v,
                               input logic [11:0] act_v);
        if (exp_v !== act_v) begin
            mismatches++;
            $display("%0t ns: %s expected %0d, got %0d", $time, name, exp_v, act_v);
        end
    endtask

    function automatic logic [7:0] rand_uri_byte(input bit no_h);
        logic [7:0] b;
        do begin
            if ($urandom_range(0, 3) != 0) b = 8'($urandom_range(33, 126));
            else b = 8'($urandom_range(0, 255));
        end while (!USUAL_MAP[b] || (no_h && b == "H"));
        return b;
    endfunction

    function automatic logic [7:0] rand_method_byte();
        case ($urandom_range(0, 9))
            0: return "_";
            1: return "-";
            2: return 8'($urandom_range(97, 122));
            default: return 8'($urandom_range(65, 90));
        endcase
    endfunction

    task automatic add_byte(input logic [7:0] b);
        line_buf.push_back(b);
    endtask

    task automatic add_text(input string s);
        for (int k = 0; k < s.len(); k++) line_buf.push_back(s[k]);
    endtask

    task automatic flush_line();
        while (line_buf.size() > 0) begin
            pending_bytes.push_back(line_buf.pop_front());
            bytes_queued++;
        end
    endtask

    task automatic add_line(input string body, input t_line_end ending);
        add_text(body);
        if (ending == END_CRLF) add_byte(CH_CR);
        if (ending != END_NONE) add_byte(CH_LF);
        flush_line();
    endtask

    task automatic add_long_line(input int uri_len);
        add_text("GET /");
        repeat (uri_len) add_byte(rand_uri_byte(1'b0));
        add_line(" HTTP/1.1", END_CRLF);
    endtask

    task automatic push_random_line();
        int flavor;
        int segs;
        int pick;
        flavor = $urandom_range(0, 19);
        if (flavor == 1)
            repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) add_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
        if (flavor == 0) repeat ($urandom_range(1, 5)) add_byte(rand_method_byte());
        else add_text("GET");
        repeat ($urandom_range(1, 2)) add_byte(" ");
        add_byte("/");
        segs = $urandom_range(0, 3);
        for (int s = 0; s < segs; s++) begin
            if (s > 0) add_byte("/");
            repeat ($urandom_range(1, 6)) add_byte(rand_uri_byte(1'b0));
            if ($urandom_range(0, 2) == 0) begin
                add_byte(".");
                repeat ($urandom_range(1, 3)) add_byte(rand_uri_byte(1'b0));
            end
        end
        if (flavor == 4) begin
            add_byte(" ");
            add_byte(rand_uri_byte(1'b1));
            repeat ($urandom_range(0, 3)) add_byte(rand_uri_byte(1'b0));
        end
        repeat ($urandom_range(1, 2)) add_byte(" ");
        add_text("HTTP/");
        if (flavor == 2) begin
            add_byte(8'($urandom_range(48, 57)));
            if ($urandom_range(0, 1) == 0) add_byte(8'($urandom_range(48, 57)));
        end else begin
            add_byte("1");
        end
        add_byte(".");
        repeat (flavor == 5 ? 4 : $urandom_range(1, 3)) add_byte(8'($urandom_range(48, 57)));
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) add_byte(" ");
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
            add_byte(CH_CR);
            add_byte(CH_LF);
        end else if (pick < 9) begin
            add_byte(CH_LF);
        end else begin
            add_byte(CH_CR);
            add_byte(8'($urandom_range(0, 255)));
        end
        if (flavor == 3)
            line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom_range(0, 255));
        flush_line();
    endtask

    task automatic wait_drained();
        while (results_seen < bytes_queued) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // send bytes from the pending queue, with random gaps between items until calm is set
    always @(negedge i_clk) begin
        if (!i_valid || byte_taken) begin
            if (send_gap > 0) begin
                send_gap = send_gap - 1;
                i_valid <= 1'b0;
            end else if (pending_bytes.size() > 0) begin
                i_valid     <= 1'b1;
                i_data_byte <= pending_bytes.pop_front();
                if (!calm && $urandom_range(0, 11) == 0) send_gap = $urandom_range(1, 13);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            i_stall <= 1'b1;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 12);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // check results first, then advance the model on an accepted byte
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                results_seen++;
                if (line_status_q.size() == 0) begin
                    mismatches++;
                    $display("%0t ns: status item %0d with none expected", $time, o_status);
                end else begin
                    want = line_status_q.pop_front();
                    status_count[want.status]++;
                    got.status      = o_status;
                    got.version     = o_http_version;
                    got.uri_begin   = o_uri_begin;
                    got.uri_finish  = o_uri_finish;
                    got.ext_begin   = o_ext_begin;
                    got.ext_present = o_ext_present;
                    got.proto_begin = o_proto_begin;
                    got.line_finish = o_line_finish;
                    got.had_space   = o_uri_had_space;
                    check_field("status", want.status, got.status);
                    check_field("http_version", want.version, got.version);
                    check_field("uri_begin", want.uri_begin, got.uri_begin);
                    check_field("uri_finish", want.uri_finish, got.uri_finish);
                    check_field("ext_begin", want.ext_begin, got.ext_begin);
                    check_field("ext_present", want.ext_present, got.ext_present);
                    check_field("proto_begin", want.proto_begin, got.proto_begin);
                    check_field("line_finish", want.line_finish, got.line_finish);
                    check_field("uri_had_space", want.had_space, got.had_space);
                end
            end
            byte_taken = i_valid && !o_stall;
            if (byte_taken) begin
                line_status_q.push_back(parse_byte(i_data_byte));
                bytes_taken++;
            end
        end else begin
            byte_taken = 1'b0;
        end
    end

    initial begin
        int random_start;
        for (int k = 0; k < 8; k++) status_count[k] = 0;
        parser_restart();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_byte(CH_CR);
        add_byte(CH_LF);
        add_byte(CH_LF);
        add_line("GET / HTTP/1.1", END_CRLF);
        add_line("GET /index.html HTTP/1.0", END_LF);
        add_line("GET   /a.b/c HTTP/1.12  ", END_CRLF);
        add_line("GET /x.txt y HTTP/1.999 ", END_LF);
        add_line("GET /dir/file.tar.gz  HTTP/1.7", END_CRLF);
        add_line("GET /x HTTP/1.1000", END_CRLF);
        add_line("POST / HTTP/1.1", END_CRLF);
        add_line("get / HTTP/1.1", END_LF);
        add_line("GETS /", END_LF);
        add_line("GE /", END_LF);
        add_line("G-_T /", END_LF);
        add_line("GET x", END_LF);
        add_line("GET //a HTTP/1.1", END_LF);
        add_line("GET /. HTTP/1.1", END_LF);
        add_text("GET /a");
        add_byte(8'h01);
        add_line("", END_LF);
        add_line("GET /a HTTP/2.0", END_CRLF);
        add_line("GET /a HTTP/0.9", END_CRLF);
        add_line("GET /a HTTP/11.1", END_CRLF);
        add_line("GET /a HTTP/1x", END_LF);
        add_line("GET /a HTTP/1.x", END_LF);
        add_line("GET /a HXTP/1.1", END_LF);
        add_line("GET /a HTTP1", END_LF);
        add_line("GET /a ", END_CRLF);
        add_text("GET /a HTTP/1.1");
        add_byte(CH_CR);
        add_line("X", END_LF);
        add_line("GET /a HTTP/1.1 x", END_LF);
        add_byte(8'h00);
        add_text("GET /");
        add_byte(8'hff);
        add_line(" HTTP/1.1", END_LF);
        // fill the line buffer exactly, then overflow it by one byte
        add_long_line(4080);
        add_long_line(4081);
        wait_drained();

        random_start = bytes_queued;
        while (bytes_queued < random_start + 700) push_random_line();
        // hold the sender until every status has come back
        wait_drained();
        while (bytes_queued < random_start + 1450) push_random_line();
        wait_drained();

        calm = 1'b1;
        while (bytes_queued < random_start + 1650) push_random_line();
        wait_drained();
        repeat (8) @(posedge i_clk);

        $display("covered %0d bytes: %0d lines done, rejects method %0d request %0d",
                 bytes_taken, status_count[ST_DONE], status_count[ST_BAD_METHOD],
                 status_count[ST_BAD_REQUEST]);
        $display("rejects version %0d, too long %0d; directed edge lines then random lines",
                 status_count[ST_BAD_VERSION], status_count[ST_TOO_LONG]);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #(15_000_000);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ files.f @@
sv/hrlp_pkg.sv
sv/hrlp_classify.sv
sv/http_request_line_parser_core.sv
tb/tb_top.sv
